// ----- hw/rtl/pmpenc_pkg.sv -----
package pmpenc_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF      = 16;
    localparam int ADDR_WIDTH_DEF = 32;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_SLOT_LIMIT     = 2'd0,
        REG_BASE_INDEX     = 2'd1,
        REG_BASE_LAST_ADDR = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    localparam logic [4:0]  SLOT_LIMIT_RST     = 5'd16;
    localparam logic [4:0]  BASE_INDEX_RST     = 5'd0;
    localparam logic [31:0] BASE_LAST_ADDR_RST = 32'd0;

    // pmpcfg A field codes
    localparam logic [7:0] A_OFF   = 8'h00;
    localparam logic [7:0] A_TOR   = 8'h08;
    localparam logic [7:0] A_NA4   = 8'h10;
    localparam logic [7:0] A_NAPOT = 8'h18;

    typedef struct packed {
        logic        mode;
        logic [7:0]  perm;
        logic [31:0] region_start;
        logic [31:0] region_size;
    } in_item_t;

    typedef struct packed {
        logic        written;
        logic [3:0]  slot;
        logic [29:0] addr_word;
        logic [7:0]  cfg_byte;
        logic        error;
        logic [4:0]  end_index;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  slot_limit;
        logic [4:0]  base_index;
        logic [31:0] base_last_addr;
    } cfg_t;

    // Allocator state as kept between items
    typedef struct packed {
        logic [4:0]  next_slot;
        logic [31:0] prev_addr_word;
    } alloc_t;

endpackage

// ----- hw/rtl/pmp_region_entry_encoder_unit.sv -----
// Channel   | Ports                                  | Beat
// ----------+----------------------------------------+-----------------------------
// input     | s_valid, s_ready, s_data (in_item_t)   | restart or one region
// result    | m_valid, m_ready, m_data (out_item_t)  | one slot write or status
// config    | psel, penable, pwrite, paddr, pwdata,  | slot_limit, base_index,
//           | prdata, pready                         | base_last_addr at 0x0/0x4/0x8
//
// An input beat lands in an input register; encoding runs in one pass from there
// into the result register. One result per cycle while m_ready keeps it drained; a
// split OFF+TOR region gives two results in turn through the single result register.
// Reset (aresetn, synchronous, active low) empties both registers and clears the
// allocator. Input accepts while the input register is empty or its beat retires in
// this cycle; a waiting result stalls input only while a beat also sits in it.
module pmp_region_entry_encoder_unit
    import pmpenc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t       cfg;

    in_item_t   in_reg;
    in_item_t   in_next;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic       phase_reg;
    logic       phase_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    out_item_t  m_data_reg;
    out_item_t  m_data_next;
    alloc_t     alloc_reg;
    alloc_t     alloc_next;

    out_item_t  res0;
    out_item_t  res1;
    logic       two;
    alloc_t     upd;
    logic       load;
    logic       retire;
    logic       s_take;

    pmpenc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmpenc_core #(
        .SLOTS      (SLOTS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_core (
        .item (in_reg),
        .cfg  (cfg),
        .cur  (alloc_reg),
        .res0 (res0),
        .res1 (res1),
        .two  (two),
        .upd  (upd)
    );

    // Load the result register when a beat is held and the register is empty or being drained
    assign load    = in_valid_reg && (!m_valid_reg || m_ready);
    // The beat retires once its final result is loaded
    assign retire  = load && (phase_reg || !two);
    assign s_ready = !in_valid_reg || retire;
    assign s_take  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        in_next       = in_reg;
        in_valid_next = in_valid_reg;
        phase_next    = phase_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        alloc_next    = alloc_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = phase_reg ? res1 : res0;
            phase_next   = !retire;
        end

        // advance the allocator only when the whole beat is out
        if (retire) begin
            alloc_next    = upd;
            in_valid_next = 1'b0;
        end

        if (s_take) begin
            in_next       = s_data;
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            alloc_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            m_valid_reg  <= m_valid_next;
            alloc_reg    <= alloc_next;
        end
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- hw/rtl/pmpenc_regs.sv -----
module pmpenc_regs
    import pmpenc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_idx_t   idx;
    logic       wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SLOT_LIMIT:     cfg_next.slot_limit     = pwdata[4:0];
                REG_BASE_INDEX:     cfg_next.base_index     = pwdata[4:0];
                REG_BASE_LAST_ADDR: cfg_next.base_last_addr = pwdata[31:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SLOT_LIMIT:     prdata = {27'd0, cfg_reg.slot_limit};
            REG_BASE_INDEX:     prdata = {27'd0, cfg_reg.base_index};
            REG_BASE_LAST_ADDR: prdata = cfg_reg.base_last_addr;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slot_limit     <= SLOT_LIMIT_RST;
            cfg_reg.base_index     <= BASE_INDEX_RST;
            cfg_reg.base_last_addr <= BASE_LAST_ADDR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/pmpenc_core.sv -----
module pmpenc_core
    import pmpenc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  in_item_t  item,
    input  cfg_t      cfg,
    input  alloc_t    cur,
    output out_item_t res0,
    output out_item_t res1,
    output logic      two,
    output alloc_t    upd
);

    localparam int AW = ADDR_WIDTH;

    // Byte address to 32-bit pmpaddr-style word
    function automatic logic [31:0] word32(input logic [AW-1:0] v);
        logic [AW+1:0] ext;
        ext = {2'b00, v} >> 2;
        return ext[31:0];
    endfunction

    logic [AW-1:0] start_a;
    logic [AW-1:0] size_a;
    logic [AW-1:0] sm1;
    logic [31:0]   end_word;
    logic [31:0]   start_word;
    logic [31:0]   napot_word;
    logic [4:0]    limit;
    logic [4:0]    idx;
    logic [4:0]    idx_p1;
    logic [4:0]    idx_p2;
    logic          tor_ok;
    logic          napot_ok;
    logic          full;
    logic          full2;
    logic [7:0]    napot_a;

    assign start_a    = AW'(item.region_start);
    assign size_a     = AW'(item.region_size);
    assign sm1        = size_a - AW'(1);
    assign end_word   = word32(start_a + size_a);
    assign start_word = {2'b00, item.region_start[31:2]};
    assign napot_word = word32(start_a | (sm1 >> 1));
    assign napot_a    = (item.region_size == 32'd4) ? A_NA4 : A_NAPOT;

    // Clamp the programmed limit to the table depth
    assign limit  = ({2'b00, cfg.slot_limit} < 7'(SLOTS)) ? cfg.slot_limit : 5'(SLOTS);
    assign idx    = cur.next_slot;
    assign idx_p1 = idx + 5'd1;
    assign idx_p2 = idx + 5'd2;
    assign full   = (idx >= limit);
    assign full2  = ({1'b0, idx} + 6'd1 >= {1'b0, limit});

    assign tor_ok   = ((idx == 5'd0) && (item.region_start == 32'd0)) ||
                      ((idx != 5'd0) && (cur.prev_addr_word == start_word));
    assign napot_ok = ((size_a & sm1) == '0) && ((start_a & sm1) == '0);

    always_comb begin
        res0 = '0;
        res1 = '0;
        two  = 1'b0;
        upd  = cur;
        res0.last = 1'b1;
        res0.end_index = idx;
        priority if (item.mode) begin
            res0.end_index     = cfg.base_index;
            upd.next_slot      = cfg.base_index;
            upd.prev_addr_word = cfg.base_last_addr;
        end else if (full) begin
            res0.error = 1'b1;
        end else if (tor_ok) begin
            res0.written       = 1'b1;
            res0.slot          = idx[3:0];
            res0.addr_word     = end_word[29:0];
            res0.cfg_byte      = item.perm | A_TOR;
            res0.end_index     = idx_p1;
            upd.next_slot      = idx_p1;
            upd.prev_addr_word = end_word;
        end else if (napot_ok) begin
            res0.written       = 1'b1;
            res0.slot          = idx[3:0];
            res0.addr_word     = napot_word[29:0];
            res0.cfg_byte      = item.perm | napot_a;
            res0.end_index     = idx_p1;
            upd.next_slot      = idx_p1;
            upd.prev_addr_word = napot_word;
        end else if (full2) begin
            res0.error = 1'b1;
        end else begin
            // OFF entry marks the start, TOR entry closes the region
            two                = 1'b1;
            res0.written       = 1'b1;
            res0.slot          = idx[3:0];
            res0.addr_word     = start_word[29:0];
            res0.cfg_byte      = A_OFF;
            res0.end_index     = idx_p1;
            res0.last          = 1'b0;
            res1.written       = 1'b1;
            res1.slot          = idx_p1[3:0];
            res1.addr_word     = end_word[29:0];
            res1.cfg_byte      = item.perm | A_TOR;
            res1.end_index     = idx_p2;
            res1.last          = 1'b1;
            upd.next_slot      = idx_p2;
            upd.prev_addr_word = end_word;
        end
    end

endmodule
